// ===== hdl/gied_pkg.sv =====
`timescale 1ns / 1ps

package gied_pkg;

  localparam int NUM_DIMS     = 3;
  localparam int MAX_DIM_SIZE = 256;
  localparam int FRAC_BITS    = 16;

  localparam int IDX_W   = 8;
  localparam int SIZE_W  = 9;
  localparam int CRD_W   = 32;
  localparam int FLAT_W  = 24;
  localparam int RANGE_W = 64;
  localparam int CFG_W   = 3;
  localparam int S12_W   = 2 * SIZE_W - 1;
  localparam int TOT_W   = FLAT_W + 1;
  localparam int QNUM_W  = CRD_W + IDX_W + 1;
  localparam int CNUM_W  = CRD_W + IDX_W + 2;

  // min 0.0, max 1.0 in Q16.16
  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(1) << (CRD_W + FRAC_BITS);

  // front stages, two divider passes, product and sum stages, coordinate divider, output
  localparam int LATENCY = 3 + 2 * (IDX_W + 1) + 2 + (CRD_W + 1) + 1;

  typedef enum logic [1:0] {
    REQ_ENC_IDX = 2'd0,
    REQ_ENC_CRD = 2'd1,
    REQ_DECODE  = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_IDX_RANGE  = 2'd1,
    ST_FLAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_DIM0_SIZE = 3'd0,
    CFG_DIM1_SIZE = 3'd1,
    CFG_DIM2_SIZE = 3'd2,
    CFG_RANGE0    = 3'd3,
    CFG_RANGE1    = 3'd4,
    CFG_RANGE2    = 3'd5
  } cfg_e;

  typedef logic [NUM_DIMS-1:0][IDX_W-1:0] idx_vec_t;

  typedef struct packed {
    req_e                req;
    idx_vec_t            tenc;
    logic [NUM_DIMS-1:0] ge_hi;
    logic [NUM_DIMS-1:0] le_lo;
    logic                idx_err;
    logic                flat_err;
  } sb1_t;

  typedef struct packed {
    req_e       req;
    idx_vec_t   eidx;
    logic [IDX_W-1:0] t0;
    logic       idx_err;
    logic       flat_err;
  } sb2_t;

  typedef struct packed {
    req_e                req;
    idx_vec_t            eidx;
    idx_vec_t            tdec;
    logic [FLAT_W-1:0]   flat;
    logic [NUM_DIMS-1:0] neg;
    logic                idx_err;
    logic                flat_err;
  } sb3_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s < SIZE_W'(2)) begin
      r = SIZE_W'(2);
    end else if (s > SIZE_W'(MAX_DIM_SIZE)) begin
      r = SIZE_W'(MAX_DIM_SIZE);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ===== hdl/gied_div.sv =====
`timescale 1ns / 1ps

module gied_div #(
  parameter int DW = 24,
  parameter int VW = 17,
  parameter int QW = 8
) (
  input  logic          clk_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [QW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int CW = (DW > VW + QW) ? DW : VW + QW;

  logic [CW-1:0] r_q [QW+1];
  logic [VW-1:0] v_q [QW+1];
  logic [QW-1:0] q_q [QW+1];

  always_ff @(posedge clk_i) begin
    r_q[0] <= CW'(dividend_i);
    v_q[0] <= divisor_i;
    q_q[0] <= '0;
  end

  // one quotient bit per stage, msb first
  for (genvar j = 1; j <= QW; j++) begin : g_stage
    logic [CW-1:0] sh;
    logic          fit;
    assign sh  = CW'(v_q[j-1]) << (QW - j);
    assign fit = (r_q[j-1] >= sh);
    always_ff @(posedge clk_i) begin
      r_q[j] <= fit ? (r_q[j-1] - sh) : r_q[j-1];
      v_q[j] <= v_q[j-1];
      q_q[j] <= q_q[j-1] | (QW'(fit) << (QW - j));
    end
  end

  assign quot_o = q_q[QW];
  assign rem_o  = r_q[QW][VW-1:0];

endmodule

// ===== hdl/gied_delay.sv =====
`timescale 1ns / 1ps

module gied_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [N-1:0] vld_q;
  logic [W-1:0] dat_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < N; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q[0] <= data_i;
    for (int i = 1; i < N; i++) begin
      dat_q[i] <= dat_q[i-1];
    end
  end

  assign valid_o = vld_q[N-1];
  assign data_o  = dat_q[N-1];

endmodule

// ===== hdl/grid_index_encode_decode_core.sv =====
`timescale 1ns / 1ps

// row-major grid index encoder / decoder, three dimensions, dimension 0 outermost
//
// items: an item is taken at a rising edge with start_i high and busy_o low;
//   busy_o stays low, so a new item can enter every cycle
// request 0 encodes in_idx*, request 1 quantizes in_coord* (Q16.16) and encodes,
//   request 2 splits in_flat into indices and grid coordinates, request 3 is a no-op
// results: one per item, shown for a single cycle with done_o high, in item order;
//   the receiver cannot hold results off
// the latency is set by the restoring dividers, one quotient bit per stage:
//   two 8-bit passes (quantize / outer split, then inner split) and one
//   32-bit pass for the coordinates
// configuration: cfg_we_i writes register cfg_index_i (sizes 0..2, ranges 3..5);
//   write only while no item is in flight
// reset clears the valid pipeline and loads sizes of 2 and ranges of 0.0 .. 1.0
module grid_index_encode_decode_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       req_type_i,
  input  logic [gied_pkg::IDX_W-1:0]       in_idx0_i,
  input  logic [gied_pkg::IDX_W-1:0]       in_idx1_i,
  input  logic [gied_pkg::IDX_W-1:0]       in_idx2_i,
  input  logic signed [gied_pkg::CRD_W-1:0] in_coord0_i,
  input  logic signed [gied_pkg::CRD_W-1:0] in_coord1_i,
  input  logic signed [gied_pkg::CRD_W-1:0] in_coord2_i,
  input  logic [gied_pkg::FLAT_W-1:0]      in_flat_i,
  input  logic                             cfg_we_i,
  input  logic [gied_pkg::CFG_W-1:0]       cfg_index_i,
  input  logic [gied_pkg::RANGE_W-1:0]     cfg_wdata_i,
  output logic                             done_o,
  output logic [gied_pkg::FLAT_W-1:0]      out_flat_o,
  output logic [gied_pkg::IDX_W-1:0]       out_idx0_o,
  output logic [gied_pkg::IDX_W-1:0]       out_idx1_o,
  output logic [gied_pkg::IDX_W-1:0]       out_idx2_o,
  output logic signed [gied_pkg::CRD_W-1:0] out_coord0_o,
  output logic signed [gied_pkg::CRD_W-1:0] out_coord1_o,
  output logic signed [gied_pkg::CRD_W-1:0] out_coord2_o,
  output logic [1:0]                       status_o
);

  import gied_pkg::*;

  // ---------------------------------------------------------------- config
  logic [SIZE_W-1:0]  size_q  [NUM_DIMS];
  logic [RANGE_W-1:0] range_q [NUM_DIMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_DIMS; k++) begin
        size_q[k]  <= SIZE_W'(2);
        range_q[k] <= RANGE_RESET;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_DIM0_SIZE: size_q[0]  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_DIM1_SIZE: size_q[1]  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_DIM2_SIZE: size_q[2]  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_RANGE0:    range_q[0] <= cfg_wdata_i;
        CFG_RANGE1:    range_q[1] <= cfg_wdata_i;
        CFG_RANGE2:    range_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamped sizes, size-1, bounds
  logic [SIZE_W-1:0]       s_eff [NUM_DIMS];
  logic [IDX_W-1:0]        sm1   [NUM_DIMS];
  logic signed [CRD_W-1:0] lo    [NUM_DIMS];
  logic signed [CRD_W-1:0] hi    [NUM_DIMS];

  for (genvar k = 0; k < NUM_DIMS; k++) begin : g_cfg
    assign s_eff[k] = eff_size(size_q[k]);
    assign sm1[k]   = IDX_W'(s_eff[k] - SIZE_W'(1));
    assign lo[k]    = range_q[k][CRD_W-1:0];
    assign hi[k]    = range_q[k][RANGE_W-1:CRD_W];
  end

  // stride of dim 0 and total point count, registered one after the other from the sizes;
  // first read by an item three stages after entry
  logic [S12_W-1:0] s12_q;
  logic [TOT_W-1:0] total_q;

  always_ff @(posedge clk_i) begin
    s12_q   <= S12_W'(s_eff[1]) * S12_W'(s_eff[2]);
    total_q <= TOT_W'(s_eff[0]) * TOT_W'(s12_q);
  end

  // ---------------------------------------------------------------- entry
  logic acc;
  assign busy_o = 1'b0;
  assign acc    = start_i & ~busy_o;

  logic                    v1_q;
  req_e                    req1_q;
  idx_vec_t                idx1_q;
  logic signed [CRD_W-1:0] crd1_q [NUM_DIMS];
  logic [FLAT_W-1:0]       flat1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req1_q    <= req_e'(req_type_i);
      idx1_q[0] <= in_idx0_i;
      idx1_q[1] <= in_idx1_i;
      idx1_q[2] <= in_idx2_i;
      crd1_q[0] <= in_coord0_i;
      crd1_q[1] <= in_coord1_i;
      crd1_q[2] <= in_coord2_i;
      flat1_q   <= in_flat_i;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // bound compares and differences; index range check with inner terms dropped
  logic [NUM_DIMS-1:0] ok2;
  idx_vec_t            tenc2_d;

  always_comb begin
    logic run;
    run = 1'b1;
    for (int k = 0; k < NUM_DIMS; k++) begin
      run        = run & ({1'b0, idx1_q[k]} < s_eff[k]);
      ok2[k]     = run;
      tenc2_d[k] = run ? idx1_q[k] : '0;
    end
  end

  logic                v2_q;
  req_e                req2_q;
  idx_vec_t            tenc2_q;
  logic [NUM_DIMS-1:0] ge2_q, le2_q;
  logic [CRD_W-1:0]    diff2_q [NUM_DIMS];
  logic [CRD_W-1:0]    den2_q  [NUM_DIMS];
  logic                idx_err2_q;
  logic [FLAT_W-1:0]   flat2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    req2_q     <= req1_q;
    tenc2_q    <= tenc2_d;
    idx_err2_q <= ~ok2[NUM_DIMS-1];
    flat2_q    <= flat1_q;
    for (int k = 0; k < NUM_DIMS; k++) begin
      ge2_q[k]   <= (crd1_q[k] >= hi[k]);
      le2_q[k]   <= (crd1_q[k] <= lo[k]);
      diff2_q[k] <= CRD_W'(crd1_q[k] - lo[k]);
      den2_q[k]  <= CRD_W'(hi[k] - lo[k]);
    end
  end

  // ---------------------------------------------------------------- stage 3
  // (x - lo) * (s - 1)
  logic                v3_q;
  req_e                req3_q;
  idx_vec_t            tenc3_q;
  logic [NUM_DIMS-1:0] ge3_q, le3_q;
  logic [QNUM_W-1:0]   num3_q [NUM_DIMS];
  logic [CRD_W-1:0]    den3_q [NUM_DIMS];
  logic                idx_err3_q;
  logic [FLAT_W-1:0]   flat3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    req3_q     <= req2_q;
    tenc3_q    <= tenc2_q;
    ge3_q      <= ge2_q;
    le3_q      <= le2_q;
    idx_err3_q <= idx_err2_q;
    flat3_q    <= flat2_q;
    for (int k = 0; k < NUM_DIMS; k++) begin
      num3_q[k] <= QNUM_W'(diff2_q[k]) * QNUM_W'(sm1[k]);
      den3_q[k] <= den2_q[k];
    end
  end

  // ---------------------------------------------------------------- divider pass 1
  // quantize: ceil(num / den); decode: flat / (s1*s2)
  idx_vec_t         qq;
  logic [IDX_W-1:0] t0;
  logic [S12_W-1:0] rem0;

  for (genvar k = 0; k < NUM_DIMS; k++) begin : g_qdiv
    logic [QNUM_W-1:0] qdvd;
    assign qdvd = num3_q[k] + QNUM_W'(den3_q[k]) - QNUM_W'(1);
    gied_div #(
      .DW(QNUM_W),
      .VW(CRD_W),
      .QW(IDX_W)
    ) u_qdiv (
      .clk_i,
      .dividend_i(qdvd),
      .divisor_i (den3_q[k]),
      .quot_o    (qq[k]),
      .rem_o     ()
    );
  end

  gied_div #(
    .DW(FLAT_W),
    .VW(S12_W),
    .QW(IDX_W)
  ) u_ddiv0 (
    .clk_i,
    .dividend_i(flat3_q),
    .divisor_i (s12_q),
    .quot_o    (t0),
    .rem_o     (rem0)
  );

  sb1_t sb1_in, sb1_out;
  logic v4;

  always_comb begin
    sb1_in.req      = req3_q;
    sb1_in.tenc     = tenc3_q;
    sb1_in.ge_hi    = ge3_q;
    sb1_in.le_lo    = le3_q;
    sb1_in.idx_err  = idx_err3_q;
    sb1_in.flat_err = ({1'b0, flat3_q} >= total_q);
  end

  gied_delay #(
    .W($bits(sb1_t)),
    .N(IDX_W + 1)
  ) u_dly1 (
    .clk_i,
    .rst_ni,
    .valid_i(v3_q),
    .data_i (sb1_in),
    .valid_o(v4),
    .data_o (sb1_out)
  );

  // ---------------------------------------------------------------- divider pass 2
  // quantized index with bound overrides; encode indices; inner decode split
  sb2_t sb2_in, sb2_out;
  logic v5;

  always_comb begin
    sb2_in.req      = sb1_out.req;
    sb2_in.t0       = t0;
    sb2_in.idx_err  = sb1_out.idx_err;
    sb2_in.flat_err = sb1_out.flat_err;
    for (int k = 0; k < NUM_DIMS; k++) begin
      logic [IDX_W-1:0] qi;
      if (sb1_out.ge_hi[k]) begin
        qi = sm1[k];
      end else if (sb1_out.le_lo[k]) begin
        qi = '0;
      end else begin
        qi = qq[k];
      end
      sb2_in.eidx[k] = (sb1_out.req == REQ_ENC_IDX) ? sb1_out.tenc[k] : qi;
    end
  end

  logic [IDX_W-1:0]  t1;
  logic [SIZE_W-1:0] rem1;

  gied_div #(
    .DW(S12_W),
    .VW(SIZE_W),
    .QW(IDX_W)
  ) u_ddiv1 (
    .clk_i,
    .dividend_i(rem0),
    .divisor_i (s_eff[2]),
    .quot_o    (t1),
    .rem_o     (rem1)
  );

  gied_delay #(
    .W($bits(sb2_t)),
    .N(IDX_W + 1)
  ) u_dly2 (
    .clk_i,
    .rst_ni,
    .valid_i(v4),
    .data_i (sb2_in),
    .valid_o(v5),
    .data_o (sb2_out)
  );

  // ---------------------------------------------------------------- product stage
  idx_vec_t tdec;
  assign tdec[0] = sb2_out.t0;
  assign tdec[1] = t1;
  assign tdec[2] = rem1[IDX_W-1:0];

  logic                     x1_v_q;
  req_e                     x1_req_q;
  idx_vec_t                 x1_eidx_q, x1_tdec_q;
  logic                     x1_idx_err_q, x1_flat_err_q;
  logic [TOT_W-1:0]         pa_q;
  logic [S12_W-1:0]         pb_q;
  logic signed [CNUM_W-1:0] clo_q [NUM_DIMS];
  logic signed [CNUM_W-1:0] cdf_q [NUM_DIMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_v_q <= 1'b0;
    end else begin
      x1_v_q <= v5;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_req_q      <= sb2_out.req;
    x1_eidx_q     <= sb2_out.eidx;
    x1_tdec_q     <= tdec;
    x1_idx_err_q  <= sb2_out.idx_err;
    x1_flat_err_q <= sb2_out.flat_err;
    pa_q          <= TOT_W'(sb2_out.eidx[0]) * TOT_W'(s12_q);
    pb_q          <= S12_W'(sb2_out.eidx[1]) * S12_W'(s_eff[2]);
    for (int k = 0; k < NUM_DIMS; k++) begin
      // lo*(s-1) and (hi-lo)*i
      clo_q[k] <= CNUM_W'(lo[k]) * CNUM_W'($signed({1'b0, sm1[k]}));
      cdf_q[k] <= (CNUM_W'(hi[k]) - CNUM_W'(lo[k])) *
                  CNUM_W'($signed({1'b0, tdec[k]}));
    end
  end

  // ---------------------------------------------------------------- sum stage
  logic                     x2_v_q;
  req_e                     x2_req_q;
  idx_vec_t                 x2_eidx_q, x2_tdec_q;
  logic                     x2_idx_err_q, x2_flat_err_q;
  logic [FLAT_W-1:0]        x2_flat_q;
  logic signed [CNUM_W-1:0] cnum_q [NUM_DIMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x2_v_q <= 1'b0;
    end else begin
      x2_v_q <= x1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x2_req_q      <= x1_req_q;
    x2_eidx_q     <= x1_eidx_q;
    x2_tdec_q     <= x1_tdec_q;
    x2_idx_err_q  <= x1_idx_err_q;
    x2_flat_err_q <= x1_flat_err_q;
    x2_flat_q     <= FLAT_W'(pa_q + TOT_W'(pb_q) + TOT_W'(x1_eidx_q[2]));
    for (int k = 0; k < NUM_DIMS; k++) begin
      cnum_q[k] <= clo_q[k] + cdf_q[k];
    end
  end

  // ---------------------------------------------------------------- coordinate divider
  // magnitude divided by s-1, sign restored at the output: truncation toward zero
  logic [NUM_DIMS-1:0] cneg;
  logic [CRD_W-1:0]    cq [NUM_DIMS];

  for (genvar k = 0; k < NUM_DIMS; k++) begin : g_cdiv
    logic [CNUM_W-1:0] mag;
    assign cneg[k] = cnum_q[k][CNUM_W-1];
    assign mag     = cneg[k] ? (~cnum_q[k] + CNUM_W'(1)) : cnum_q[k];
    gied_div #(
      .DW(CNUM_W),
      .VW(IDX_W),
      .QW(CRD_W)
    ) u_cdiv (
      .clk_i,
      .dividend_i(mag),
      .divisor_i (sm1[k]),
      .quot_o    (cq[k]),
      .rem_o     ()
    );
  end

  sb3_t sb3_in, sb3_out;
  logic v6;

  always_comb begin
    sb3_in.req      = x2_req_q;
    sb3_in.eidx     = x2_eidx_q;
    sb3_in.tdec     = x2_tdec_q;
    sb3_in.flat     = x2_flat_q;
    sb3_in.neg      = cneg;
    sb3_in.idx_err  = x2_idx_err_q;
    sb3_in.flat_err = x2_flat_err_q;
  end

  gied_delay #(
    .W($bits(sb3_t)),
    .N(CRD_W + 1)
  ) u_dly3 (
    .clk_i,
    .rst_ni,
    .valid_i(x2_v_q),
    .data_i (sb3_in),
    .valid_o(v6),
    .data_o (sb3_out)
  );

  // ---------------------------------------------------------------- result register
  logic [FLAT_W-1:0] flat_d, flat_q;
  idx_vec_t          oidx_d, oidx_q;
  logic [CRD_W-1:0]  ocrd_d [NUM_DIMS];
  logic [CRD_W-1:0]  ocrd_q [NUM_DIMS];
  status_e           st_d, st_q;
  logic              done_q;

  always_comb begin
    flat_d = '0;
    oidx_d = '0;
    st_d   = ST_OK;
    for (int k = 0; k < NUM_DIMS; k++) begin
      ocrd_d[k] = '0;
    end
    unique case (sb3_out.req)
      REQ_ENC_IDX: begin
        flat_d = sb3_out.flat;
        st_d   = sb3_out.idx_err ? ST_IDX_RANGE : ST_OK;
      end
      REQ_ENC_CRD: begin
        flat_d = sb3_out.flat;
        oidx_d = sb3_out.eidx;
      end
      REQ_DECODE: begin
        if (sb3_out.flat_err) begin
          st_d = ST_FLAT_RANGE;
        end else begin
          oidx_d = sb3_out.tdec;
          for (int k = 0; k < NUM_DIMS; k++) begin
            ocrd_d[k] = sb3_out.neg[k] ? (~cq[k] + CRD_W'(1)) : cq[k];
          end
        end
      end
      REQ_NOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v6;
    end
  end

  always_ff @(posedge clk_i) begin
    flat_q <= flat_d;
    oidx_q <= oidx_d;
    st_q   <= st_d;
    for (int k = 0; k < NUM_DIMS; k++) begin
      ocrd_q[k] <= ocrd_d[k];
    end
  end

  assign done_o       = done_q;
  assign out_flat_o   = flat_q;
  assign out_idx0_o   = oidx_q[0];
  assign out_idx1_o   = oidx_q[1];
  assign out_idx2_o   = oidx_q[2];
  assign out_coord0_o = ocrd_q[0];
  assign out_coord1_o = ocrd_q[1];
  assign out_coord2_o = ocrd_q[2];
  assign status_o     = st_q;

  // ---------------------------------------------------------------- checks
  // every accepted item comes out after the fixed latency
  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LATENCY done_o)
    else $error("item accepted without a result after the pipeline latency");

  // no result without an item accepted at the matching edge
  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, LATENCY))
    else $error("result strobe without a matching accepted item");

  // a rejected flat index leaves indices and coordinates at zero
  a_flat_err_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FLAT_RANGE) |->
      (out_flat_o == '0 && out_idx0_o == '0 && out_idx1_o == '0 && out_idx2_o == '0 &&
       out_coord0_o == '0 && out_coord1_o == '0 && out_coord2_o == '0))
    else $error("flat range error with nonzero result fields");

endmodule
